>>> rtl/core/sgb_pkg.sv
// Shared constants and types for the short segment blender.
package sgb_pkg;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_TARGET_LABEL = 2'd0;
  localparam logic [1:0] REG_LEN_LIMIT    = 2'd1;
  localparam logic [1:0] REG_MAX_GAP      = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  typedef struct packed {
    logic [1:0] count;
    logic       last;
  } rec_ctl_t;

endpackage

>>> rtl/core/sgb_cfg.sv
// Configuration registers behind the APB-style port.
module sgb_cfg
  import sgb_pkg::*;
#(
  parameter int FRAME_BITS = 24,
  parameter int LABEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LABEL_BITS-1:0] target_label,
  output logic [FRAME_BITS-1:0] len_limit,
  output logic [FRAME_BITS-1:0] max_gap
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_label <= '0;
      len_limit    <= '0;
      max_gap      <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_TARGET_LABEL: target_label <= pwdata[LABEL_BITS-1:0];
        REG_LEN_LIMIT:    len_limit    <= pwdata[FRAME_BITS-1:0];
        REG_MAX_GAP:      max_gap      <= pwdata[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TARGET_LABEL: prdata = APB_DATA_W'(target_label);
      REG_LEN_LIMIT:    prdata = APB_DATA_W'(len_limit);
      REG_MAX_GAP:      prdata = APB_DATA_W'(max_gap);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/sgb_front.sv
// Window of previous and current segments, blend decision and request building.
module sgb_front
  import sgb_pkg::*;
#(
  parameter int FRAME_BITS = 24,
  parameter int LABEL_BITS = 16,
  localparam int SEG_W     = 2 * FRAME_BITS + LABEL_BITS,
  localparam int REC_W     = 3 * SEG_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [FRAME_BITS-1:0] seg_start,
  input  logic [FRAME_BITS-1:0] seg_end,
  input  logic [LABEL_BITS-1:0] seg_label,
  input  logic                  in_last,
  input  logic [LABEL_BITS-1:0] target_label,
  input  logic [FRAME_BITS-1:0] len_limit,
  input  logic [FRAME_BITS-1:0] max_gap,
  output logic                  rec_push,
  output rec_ctl_t              rec_ctl,
  output logic [REC_W-1:0]      rec_data
);

  localparam int EXT_W = FRAME_BITS + 2;

  logic                  prev_valid, prev_valid_next;
  logic [FRAME_BITS-1:0] prev_start, prev_start_next;
  logic [FRAME_BITS-1:0] prev_end, prev_end_next;
  logic [LABEL_BITS-1:0] prev_label, prev_label_next;
  logic                  cur_valid, cur_valid_next;
  logic [FRAME_BITS-1:0] cur_start, cur_start_next;
  logic [FRAME_BITS-1:0] cur_end, cur_end_next;
  logic [LABEL_BITS-1:0] cur_label, cur_label_next;

  logic [EXT_W-1:0] seg_len, gap_next, gap_prev, max_len_ext, max_gap_ext;
  logic             blend, slide;
  logic [SEG_W-1:0] old_prev_seg, win_prev_seg, win_cur_seg, in_seg;
  logic [1:0]       flush_count;

  assign seg_len     = {2'b00, cur_end} - {2'b00, cur_start} + EXT_W'(1);
  assign gap_next    = {2'b00, seg_start} - {2'b00, cur_end} - EXT_W'(1);
  assign gap_prev    = {2'b00, cur_start} - {2'b00, prev_end} - EXT_W'(1);
  assign max_len_ext = {2'b00, len_limit};
  assign max_gap_ext = {2'b00, max_gap};

  assign blend = prev_valid && cur_valid
              && (seg_label == prev_label)
              && (cur_label == target_label)
              && ($signed(seg_len) < $signed(max_len_ext))
              && ($signed(gap_next) <= $signed(max_gap_ext))
              && ($signed(gap_prev) <= $signed(max_gap_ext));
  assign slide = prev_valid && cur_valid && !blend;

  assign old_prev_seg = {prev_start, prev_end, prev_label};
  assign in_seg       = {seg_start, seg_end, seg_label};

  always_comb begin
    prev_valid_next = prev_valid;
    prev_start_next = prev_start;
    prev_end_next   = prev_end;
    prev_label_next = prev_label;
    cur_valid_next  = cur_valid;
    cur_start_next  = cur_start;
    cur_end_next    = cur_end;
    cur_label_next  = cur_label;
    priority if (!prev_valid) begin
      prev_valid_next = 1'b1;
      prev_start_next = seg_start;
      prev_end_next   = seg_end;
      prev_label_next = seg_label;
    end else if (!cur_valid) begin
      cur_valid_next = 1'b1;
      cur_start_next = seg_start;
      cur_end_next   = seg_end;
      cur_label_next = seg_label;
    end else if (blend) begin
      prev_end_next  = seg_end;
      cur_valid_next = 1'b0;
    end else begin
      prev_start_next = cur_start;
      prev_end_next   = cur_end;
      prev_label_next = cur_label;
      cur_start_next  = seg_start;
      cur_end_next    = seg_end;
      cur_label_next  = seg_label;
    end
  end

  assign win_prev_seg = {prev_start_next, prev_end_next, prev_label_next};
  assign win_cur_seg  = {cur_start_next, cur_end_next, cur_label_next};
  assign flush_count  = in_last ? (cur_valid_next ? 2'd2 : 2'd1) : 2'd0;

  always_comb begin
    rec_ctl.last = in_last;
    if (slide) begin
      rec_ctl.count = 2'd1 + flush_count;
      rec_data      = {old_prev_seg, win_prev_seg, win_cur_seg};
    end else begin
      rec_ctl.count = flush_count;
      rec_data      = {win_prev_seg, win_cur_seg, in_seg};
    end
  end

  assign rec_push = accept && (rec_ctl.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      cur_valid  <= 1'b0;
    end else if (accept) begin
      prev_valid <= prev_valid_next && !in_last;
      cur_valid  <= cur_valid_next && !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_start <= prev_start_next;
      prev_end   <= prev_end_next;
      prev_label <= prev_label_next;
      cur_start  <= cur_start_next;
      cur_end    <= cur_end_next;
      cur_label  <= cur_label_next;
    end
  end

endmodule

>>> rtl/core/sgb_queue.sv
// Short request queue between the window logic and the result sequencer.
module sgb_queue
  import sgb_pkg::*;
#(
  parameter int DATA_W = 192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  rec_ctl_t          push_ctl,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop_en,
  output rec_ctl_t          head_ctl,
  output logic [DATA_W-1:0] head_data,
  output logic              q_full,
  output logic              q_empty
);

  rec_ctl_t             ctl_mem  [QUEUE_DEPTH];
  logic [DATA_W-1:0]    data_mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;

  assign q_full    = (fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign q_empty   = (fill == '0);
  assign head_ctl  = ctl_mem[rd_ptr];
  assign head_data = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + 1'b1;
      if (pop_en)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push_en, pop_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      ctl_mem[wr_ptr]  <= push_ctl;
      data_mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/sgb_back.sv
// Result sequencer: walks the segments of the head request, one per pop.
module sgb_back
  import sgb_pkg::*;
#(
  parameter int FRAME_BITS = 24,
  parameter int LABEL_BITS = 16,
  localparam int SEG_W     = 2 * FRAME_BITS + LABEL_BITS,
  localparam int REC_W     = 3 * SEG_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rec_ctl_t              head_ctl,
  input  logic [REC_W-1:0]      head_data,
  input  logic                  q_empty,
  input  logic                  pop,
  output logic                  rec_pop,
  output logic                  empty,
  output logic [FRAME_BITS-1:0] out_start,
  output logic [FRAME_BITS-1:0] out_end,
  output logic [LABEL_BITS-1:0] out_label,
  output logic                  out_last
);

  logic [1:0]       slot;
  logic             final_slot;
  logic             take;
  logic [SEG_W-1:0] sel_seg;

  assign empty      = q_empty;
  assign take       = pop && !q_empty;
  assign final_slot = (slot == head_ctl.count - 2'd1);
  assign rec_pop    = take && final_slot;

  always_comb begin
    unique case (slot)
      SLOT_FIRST:  sel_seg = head_data[3*SEG_W-1:2*SEG_W];
      SLOT_SECOND: sel_seg = head_data[2*SEG_W-1:SEG_W];
      SLOT_THIRD:  sel_seg = head_data[SEG_W-1:0];
      default:     sel_seg = head_data[SEG_W-1:0];
    endcase
  end

  assign out_start = sel_seg[SEG_W-1:FRAME_BITS+LABEL_BITS];
  assign out_end   = sel_seg[FRAME_BITS+LABEL_BITS-1:LABEL_BITS];
  assign out_label = sel_seg[LABEL_BITS-1:0];
  assign out_last  = head_ctl.last && final_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_FIRST;
    end else if (take) begin
      slot <= final_slot ? SLOT_FIRST : slot + 2'd1;
    end
  end

endmodule

>>> rtl/core/short_segment_blender_top.sv
// Top level of the short segment blender.
// Accepts one segment per cycle while full is low. Each accepted segment
// passes the two-entry window and leaves zero to three results as one
// request in a four-deep queue; results leave one per cycle while pop is
// high and empty is low, so the sustained rate is one segment per cycle
// when each segment yields at most one result, and is set by the single
// result port otherwise. The user must write configuration through the
// APB-style port only while the block is idle; the block does not check this.
module short_segment_blender_top
  import sgb_pkg::*;
#(
  parameter int FRAME_BITS = 24,
  parameter int LABEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [FRAME_BITS-1:0] seg_start,
  input  logic [FRAME_BITS-1:0] seg_end,
  input  logic [LABEL_BITS-1:0] seg_label,
  input  logic                  in_last,
  output logic                  empty,
  input  logic                  pop,
  output logic [FRAME_BITS-1:0] out_start,
  output logic [FRAME_BITS-1:0] out_end,
  output logic [LABEL_BITS-1:0] out_label,
  output logic                  out_last
);

  localparam int SEG_W = 2 * FRAME_BITS + LABEL_BITS;
  localparam int REC_W = 3 * SEG_W;

  logic [LABEL_BITS-1:0] target_label;
  logic [FRAME_BITS-1:0] len_limit;
  logic [FRAME_BITS-1:0] max_gap;
  logic                  accept;
  logic                  rec_push;
  rec_ctl_t              rec_ctl;
  logic [REC_W-1:0]      rec_data;
  logic                  rec_pop;
  rec_ctl_t              head_ctl;
  logic [REC_W-1:0]      head_data;
  logic                  q_full;
  logic                  q_empty;

  assign full   = q_full;
  assign accept = push && !q_full;

  sgb_cfg #(
    .FRAME_BITS (FRAME_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .target_label (target_label),
    .len_limit    (len_limit),
    .max_gap      (max_gap)
  );

  sgb_front #(
    .FRAME_BITS (FRAME_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .seg_label    (seg_label),
    .in_last      (in_last),
    .target_label (target_label),
    .len_limit    (len_limit),
    .max_gap      (max_gap),
    .rec_push     (rec_push),
    .rec_ctl      (rec_ctl),
    .rec_data     (rec_data)
  );

  sgb_queue #(
    .DATA_W (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (rec_push),
    .push_ctl  (rec_ctl),
    .push_data (rec_data),
    .pop_en    (rec_pop),
    .head_ctl  (head_ctl),
    .head_data (head_data),
    .q_full    (q_full),
    .q_empty   (q_empty)
  );

  sgb_back #(
    .FRAME_BITS (FRAME_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_ctl  (head_ctl),
    .head_data (head_data),
    .q_empty   (q_empty),
    .pop       (pop),
    .rec_pop   (rec_pop),
    .empty     (empty),
    .out_start (out_start),
    .out_end   (out_end),
    .out_label (out_label),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_head_not_blank: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (head_ctl.count != 2'd0))
    else $error("queued request carries no result");

  a_last_closes_request: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_last) |-> rec_pop)
    else $error("final result popped without retiring its request");
`endif

endmodule

>>> verif/short_segment_blender_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of the short segment blender: random lists, gaps and stalls.
module short_segment_blender_top_test;
  import sgb_pkg::*;

  localparam int FRAME_BITS = 24;
  localparam int LABEL_BITS = 16;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
  localparam logic [LABEL_BITS-1:0] LABEL_MAX = '1;

  typedef struct packed {
    logic [FRAME_BITS-1:0] sframe;
    logic [FRAME_BITS-1:0] eframe;
    logic [LABEL_BITS-1:0] label;
    logic                  tail;
  } segment_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push = 1'b0;
  logic                  full;
  logic [FRAME_BITS-1:0] seg_start = '0;
  logic [FRAME_BITS-1:0] seg_end = '0;
  logic [LABEL_BITS-1:0] seg_label = '0;
  logic                  in_last = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [FRAME_BITS-1:0] out_start;
  logic [FRAME_BITS-1:0] out_end;
  logic [LABEL_BITS-1:0] out_label;
  logic                  out_last;

  segment_t seg_queue[$];
  segment_t blended_q[$];

  logic [LABEL_BITS-1:0] cfg_target = '0;
  logic [FRAME_BITS-1:0] cfg_len_limit = '0;
  logic [FRAME_BITS-1:0] cfg_max_gap = '0;

  segment_t win_prev = '0;
  segment_t win_cur = '0;
  bit       win_prev_valid = 1'b0;
  bit       win_cur_valid = 1'b0;

  int mismatch_count = 0;
  bit seg_taken = 1'b0;
  int send_wait = 0;
  int take_wait = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  short_segment_blender_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .seg_start(seg_start),
    .seg_end  (seg_end),
    .seg_label(seg_label),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_start(out_start),
    .out_end  (out_end),
    .out_label(out_label),
    .out_last (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[short_segment_blender_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 9);
    if (burst) return 0;
    if (r < 6) return $urandom_range(0, 2);
    if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic segment_t with_tail(input segment_t s, input bit t);
    segment_t r;
    r = s;
    r.tail = t;
    return r;
  endfunction

  // Advance the two-entry window by one segment and append what it emits.
  function automatic void blend_step(input segment_t seg);
    longint span;
    longint gap_before;
    longint gap_after;
    bit     fold;
    if (!win_prev_valid) begin
      win_prev = with_tail(seg, 1'b0);
      win_prev_valid = 1'b1;
    end else if (!win_cur_valid) begin
      win_cur = with_tail(seg, 1'b0);
      win_cur_valid = 1'b1;
    end else begin
      span = longint'(win_cur.eframe) - longint'(win_cur.sframe) + 1;
      gap_after = longint'(seg.sframe) - longint'(win_cur.eframe) - 1;
      gap_before = longint'(win_cur.sframe) - longint'(win_prev.eframe) - 1;
      fold = (seg.label == win_prev.label) && (win_cur.label == cfg_target) &&
             (span < longint'(cfg_len_limit)) &&
             (gap_after <= longint'(cfg_max_gap)) &&
             (gap_before <= longint'(cfg_max_gap));
      if (fold) begin
        win_prev.eframe = seg.eframe;
        win_cur = '0;
        win_cur_valid = 1'b0;
      end else begin
        blended_q.push_back(with_tail(win_prev, 1'b0));
        win_prev = win_cur;
        win_cur = with_tail(seg, 1'b0);
      end
    end
    if (seg.tail) begin
      if (win_cur_valid) begin
        blended_q.push_back(with_tail(win_prev, 1'b0));
        blended_q.push_back(with_tail(win_cur, 1'b1));
      end else begin
        blended_q.push_back(with_tail(win_prev, 1'b1));
      end
      win_prev = '0;
      win_cur = '0;
      win_prev_valid = 1'b0;
      win_cur_valid = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    segment_t want;
    seg_taken <= !rst && push && !full;
    if (!rst && push && !full) begin
      blend_step('{seg_start, seg_end, seg_label, in_last});
    end
    if (!rst && pop && !empty) begin
      if (blended_q.size() == 0) begin
        report_mismatch($sformatf("result %0h..%0h label %0h with none waiting",
                                  out_start, out_end, out_label));
      end else begin
        want = blended_q.pop_front();
        if (out_start !== want.sframe)
          report_mismatch($sformatf("out_start %0h, want %0h", out_start, want.sframe));
        if (out_end !== want.eframe)
          report_mismatch($sformatf("out_end %0h, want %0h", out_end, want.eframe));
        if (out_label !== want.label)
          report_mismatch($sformatf("out_label %0h, want %0h", out_label, want.label));
        if (out_last !== want.tail)
          report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.tail));
      end
    end
  end

  always @(negedge clk) begin
    segment_t s;
    if (!rst && (!push || seg_taken)) begin
      if (send_wait > 0) begin
        push <= 1'b0;
        send_wait--;
      end else if (seg_queue.size() > 0) begin
        s = seg_queue.pop_front();
        seg_start <= s.sframe;
        seg_end <= s.eframe;
        seg_label <= s.label;
        in_last <= s.tail;
        push <= 1'b1;
        send_wait = pick_gap(send_burst);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (take_wait > 0) begin
      pop <= 1'b0;
      take_wait--;
    end else begin
      pop <= 1'b1;
      take_wait = pick_gap(take_burst);
      if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET_LABEL: cfg_target = value[LABEL_BITS-1:0];
      REG_LEN_LIMIT:    cfg_len_limit = value[FRAME_BITS-1:0];
      REG_MAX_GAP:      cfg_max_gap = value[FRAME_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [LABEL_BITS-1:0] target,
                            input logic [FRAME_BITS-1:0] max_len,
                            input logic [FRAME_BITS-1:0] max_gap);
    write_reg(REG_TARGET_LABEL, APB_DATA_W'(target));
    write_reg(REG_LEN_LIMIT, APB_DATA_W'(max_len));
    write_reg(REG_MAX_GAP, APB_DATA_W'(max_gap));
  endtask

  task automatic add_seg(input logic [FRAME_BITS-1:0] s, input logic [FRAME_BITS-1:0] e,
                         input logic [LABEL_BITS-1:0] l, input bit t);
    seg_queue.push_back('{s, e, l, t});
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (seg_queue.size() != 0 || push || blended_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Queue a mostly sorted list whose odd slots mostly carry the target label.
  task automatic add_list(input int n);
    logic [LABEL_BITS-1:0] lab_a;
    logic [LABEL_BITS-1:0] lab_b;
    logic [FRAME_BITS-1:0] pos;
    segment_t s;
    int len;
    int gap_v;
    lab_a = LABEL_BITS'($urandom);
    lab_b = LABEL_BITS'($urandom);
    pos = ($urandom_range(0, 3) == 0) ? FRAME_BITS'($urandom_range(FRAME_MAX - 4000, FRAME_MAX))
                                      : FRAME_BITS'($urandom_range(0, 100000));
    for (int i = 0; i < n; i++) begin
      if (i % 2 == 1 && $urandom_range(0, 3) != 0) s.label = cfg_target;
      else s.label = ($urandom_range(0, 4) == 0) ? lab_b : lab_a;
      len = (s.label == cfg_target) ? $urandom_range(1, 24) : $urandom_range(1, 400);
      gap_v = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 5000) : $urandom_range(0, 6);
      s.sframe = pos + FRAME_BITS'(gap_v);
      s.eframe = s.sframe + FRAME_BITS'(len - 1);
      if ($urandom_range(0, 15) == 0) s.eframe = s.sframe - FRAME_BITS'($urandom_range(1, 5));
      pos = s.eframe + 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        s.sframe = FRAME_BITS'($urandom);
        s.eframe = FRAME_BITS'($urandom);
        s.label = LABEL_BITS'($urandom);
      end
      s.tail = (i == n - 1) && ($urandom_range(0, 7) != 0);
      seg_queue.push_back(s);
    end
  endtask

  initial begin
    int phase_items;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_seg(100, 110, 7, 1'b1);
    add_seg(5, 4, 0, 1'b0);
    add_seg(6, 2, 0, 1'b0);
    add_seg(7, 7, 0, 1'b1);
    wait_drained();

    set_config(5, 10, 3);
    add_seg(0, 10, 1, 1'b0);
    add_seg(12, 14, 5, 1'b0);
    add_seg(16, 30, 1, 1'b0);
    add_seg(32, 33, 5, 1'b0);
    add_seg(35, 40, 1, 1'b0);
    add_seg(41, 50, 2, 1'b1);
    add_seg(FRAME_MAX, 0, LABEL_MAX, 1'b0);
    add_seg(0, FRAME_MAX, 0, 1'b1);
    add_seg(1000, 2000, 3, 1'b0);
    add_seg(2001, 1990, 5, 1'b0);
    add_seg(1992, 1500, 3, 1'b0);
    add_seg(1600, 1700, 4, 1'b1);
    add_seg(50, 60, 9, 1'b0);
    add_seg(70, 80, 9, 1'b1);
    add_seg(200, 210, 1, 1'b0);
    add_seg(300, 310, 2, 1'b0);
    add_seg(400, 410, 3, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(LABEL_BITS'($urandom), FRAME_BITS'($urandom_range(1, 30)),
                      FRAME_BITS'($urandom_range(0, 8)));
        1: set_config(LABEL_MAX, FRAME_MAX, FRAME_MAX);
        2: set_config(0, 0, 0);
        3: set_config(LABEL_BITS'($urandom), FRAME_BITS'($urandom_range(0, 64)),
                      FRAME_BITS'($urandom_range(0, 16)));
        default: set_config(LABEL_BITS'($urandom), FRAME_MAX, 0);
      endcase
      phase_items = seg_queue.size();
      while (seg_queue.size() - phase_items < 40) begin
        add_list(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 9));
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("[short_segment_blender_top] OK");
    end else begin
      $display("[short_segment_blender_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sgb_pkg.sv
rtl/core/sgb_cfg.sv
rtl/core/sgb_front.sv
rtl/core/sgb_queue.sv
rtl/core/sgb_back.sv
rtl/core/short_segment_blender_top.sv
verif/short_segment_blender_top_test.sv
